/* rtl/csm_pkg.sv */
// Shared constants, types and helpers for the CSR sparse matrix-vector core.
`timescale 1ns / 1ps

package csm_pkg;

  // Depth of the on-chip vector store and the address width that follows from it
  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_ADDR_W   = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  // Field widths of the stream items
  localparam int CMD_W    = 2;
  localparam int COL_W    = 10;
  localparam int VAL_W    = 32;
  localparam int SUM_W    = 64;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 2'd0,
    CMD_NONZERO   = 2'd1,
    CMD_EMPTY_ROW = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                    overflow;
    logic signed [SUM_W-1:0] row_sum;
  } result_t;

  // Saturating 64-bit signed add; sat reports a clamp
  function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
                                             input logic signed [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    logic             sat;
    s   = a + b;
    sat = 1'b0;
    if (!a[SUM_W-1] && !b[SUM_W-1] && s[SUM_W-1]) begin
      s   = {1'b0, {(SUM_W-1){1'b1}}};
      sat = 1'b1;
    end else if (a[SUM_W-1] && b[SUM_W-1] && !s[SUM_W-1]) begin
      s   = {1'b1, {(SUM_W-1){1'b0}}};
      sat = 1'b1;
    end
    return {sat, s};
  endfunction

endpackage

/* rtl/csm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/csm_out_fifo.sv */
// Small result queue that decouples the accumulator from the output stream.
`timescale 1ns / 1ps

module csm_out_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  csm_pkg::result_t                 push_data,
  output logic                             pop_valid,
  input  logic                             pop,
  output csm_pkg::result_t                 pop_data,
  output logic [csm_pkg::FIFO_CNT_W-1:0]   count
);

  csm_pkg::result_t                entries [csm_pkg::FIFO_DEPTH];
  logic [csm_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [csm_pkg::FIFO_PTR_W-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

endmodule

/* rtl/csr_sparse_matvec_core.sv */
// Top level of the CSR sparse matrix-vector multiply core.
// Usage:
//   Input stream (s_axis_*): one request per item. tuser carries the command
//   (load vector element, matrix nonzero, end of empty row), tlast marks the
//   last nonzero of a row, tdata carries column index and Q16.16 value.
//   Output stream (m_axis_*): one request per finished row; tdata is the
//   saturated Q32.32 row sum, tuser the overflow flag.
// Throughput: one item per cycle while s_axis_tready is high. The vector store is read once
//   per nonzero through its single read port, the 32x32 multiplier and the
//   64-bit accumulator each take one item a cycle.
// Path: a row-closing item passes the RAM read into mul_stage, the multiply
//   into acc_stage, and the accumulate into the result queue, which raises m_axis_tvalid.
// Loads write the store at the accept edge, so a nonzero in the very next
//   cycle already sees the new element.
// Stalls: a four-entry result queue sits before the output. s_axis_tready
//   drops only when the queue plus the row ends still in flight would fill
//   it, so input keeps flowing while a result waits to be taken.
// Reset: clears accumulator, overflow flag, pipeline and queue. The vector
//   store is not cleared; load every element before it is used.
`timescale 1ns / 1ps

module csr_sparse_matvec_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] column_index, [41:10] element_value, [47:42] zero
  input  logic [csm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] command
  input  logic [csm_pkg::CMD_W-1:0]         s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] row_sum
  output logic [csm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] overflow
  output logic                              m_axis_tuser
);

  typedef struct packed {
    logic                           valid;
    logic                           is_nz;
    logic                           in_range;
    logic                           emit;
    logic signed [csm_pkg::VAL_W-1:0] value;
  } mul_stage_t;

  typedef struct packed {
    logic                           valid;
    logic                           emit;
    logic signed [csm_pkg::SUM_W-1:0] product;
  } acc_stage_t;

  logic                              accept;
  csm_pkg::cmd_t                     cmd;
  logic [csm_pkg::COL_W-1:0]         col;
  logic [csm_pkg::VAL_W-1:0]         val;
  logic [csm_pkg::VEC_ADDR_W-1:0]    vec_addr;
  logic                              col_in_range;
  logic                              do_load;
  logic                              do_read;
  logic [csm_pkg::VAL_W-1:0]         vec_rdata;

  mul_stage_t                        mul_stage;
  acc_stage_t                        acc_stage;
  logic signed [csm_pkg::VAL_W-1:0]  vec_elem;

  logic signed [csm_pkg::SUM_W-1:0]  row_accumulator;
  logic                              row_saturated;
  logic [csm_pkg::SUM_W:0]           add_res;
  logic                              sum_sat;
  csm_pkg::result_t                  push_data;
  csm_pkg::result_t                  pop_data;
  logic [csm_pkg::FIFO_CNT_W-1:0]    fifo_count;
  logic [csm_pkg::FIFO_CNT_W:0]      pending;

  assign cmd      = csm_pkg::cmd_t'(s_axis_tuser);
  assign col      = s_axis_tdata[csm_pkg::COL_W-1:0];
  assign val      = s_axis_tdata[csm_pkg::COL_W +: csm_pkg::VAL_W];
  assign vec_addr = csm_pkg::VEC_ADDR_W'(col);
  assign col_in_range = (32'(col) < 32'(csm_pkg::VECTOR_DEPTH));

  // Credit for the result queue: count queued results and row ends in flight
  assign pending = {1'b0, fifo_count}
                 + (csm_pkg::FIFO_CNT_W+1)'(mul_stage.valid && mul_stage.emit)
                 + (csm_pkg::FIFO_CNT_W+1)'(acc_stage.valid && acc_stage.emit);
  assign s_axis_tready = (pending < (csm_pkg::FIFO_CNT_W+1)'(csm_pkg::FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign do_load = accept && (cmd == csm_pkg::CMD_LOAD) && col_in_range;
  assign do_read = accept && (cmd == csm_pkg::CMD_NONZERO) && col_in_range;

  csm_ram #(
    .WIDTH (csm_pkg::VAL_W),
    .DEPTH (csm_pkg::VECTOR_DEPTH)
  ) u_vector_store (
    .clk   (clk),
    .we    (do_load),
    .waddr (vec_addr),
    .wdata (val),
    .re    (do_read),
    .raddr (vec_addr),
    .rdata (vec_rdata)
  );

  // Columns beyond the store read as zero
  assign vec_elem = mul_stage.in_range ? $signed(vec_rdata) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_stage.valid <= 1'b0;
      acc_stage.valid <= 1'b0;
    end else begin
      mul_stage.valid <= accept && ((cmd == csm_pkg::CMD_NONZERO) ||
                                    (cmd == csm_pkg::CMD_EMPTY_ROW));
      acc_stage.valid <= mul_stage.valid;
    end
    mul_stage.is_nz    <= (cmd == csm_pkg::CMD_NONZERO);
    mul_stage.in_range <= col_in_range;
    mul_stage.emit     <= (cmd == csm_pkg::CMD_EMPTY_ROW) || s_axis_tlast;
    mul_stage.value    <= $signed(val);
    acc_stage.emit     <= mul_stage.emit;
    // An empty-row item adds nothing and only closes the row
    acc_stage.product  <= mul_stage.is_nz ? (csm_pkg::SUM_W'(mul_stage.value) *
                                             csm_pkg::SUM_W'(vec_elem)) : '0;
  end

  assign add_res = csm_pkg::sat_add(row_accumulator, acc_stage.product);
  assign sum_sat = add_res[csm_pkg::SUM_W];

  always_comb begin
    push_data.row_sum  = add_res[csm_pkg::SUM_W-1:0];
    push_data.overflow = row_saturated || sum_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_accumulator <= '0;
      row_saturated   <= 1'b0;
    end else if (acc_stage.valid) begin
      if (acc_stage.emit) begin
        row_accumulator <= '0;
        row_saturated   <= 1'b0;
      end else begin
        row_accumulator <= add_res[csm_pkg::SUM_W-1:0];
        row_saturated   <= row_saturated || sum_sat;
      end
    end
  end

  csm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (acc_stage.valid && acc_stage.emit),
    .push_data (push_data),
    .pop_valid (m_axis_tvalid),
    .pop       (m_axis_tvalid && m_axis_tready),
    .pop_data  (pop_data),
    .count     (fifo_count)
  );

  assign m_axis_tdata = pop_data.row_sum;
  assign m_axis_tuser = pop_data.overflow;

endmodule

/* rtl/csm_checker.sv */
// Port-level checks on the CSR sparse matrix-vector core, bound to the top level.
`timescale 1ns / 1ps

module csm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [csm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  // Nothing is queued straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // Input back-pressure only arises with results waiting at the output
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind csr_sparse_matvec_core csm_checker u_csm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
